/* rtl/sida_pkg.sv */
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types, character codes and the BCD adjust step for the signed
// integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam logic [6:0] ASCII_ZERO  = 7'd48;
  localparam logic [6:0] ASCII_MINUS = 7'd45;
  localparam logic [6:0] ASCII_NINE  = 7'd57;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } sida_state_t;

  // add-3 correction of one BCD digit ahead of the shift
  function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? (d + 4'd3) : d;
    return r;
  endfunction

endpackage

/* rtl/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a two's-complement integer into its decimal ASCII text, one
// character per output request, most significant first, last one flagged.
// ----------------------------------------------------------------------------
// Sequence: a shift-and-add-3 pass over every magnitude bit, then leading zero digits
//   are skipped (at least one digit kept), a minus sign is sent if negative, then each
//   digit in turn; a stalled output holds back the sign and the digits.
// Requests: one at a time; a new value is taken only after the last digit has been
//   issued, set by the single BCD shift register that converts and outputs.
// Reset: synchronous, active low; clears the sequencer and the output valid.
module signed_int_to_decimal_ascii #(
  parameter int INT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [INT_BITS-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [6:0]                 out_char_code,
  output logic                       out_last
);
  import sida_pkg::*;

  localparam int NDIG   = (INT_BITS * 30103) / 100000 + 1;
  localparam int BCD_W  = NDIG * 4;
  localparam int BCNT_W = $clog2(INT_BITS);
  localparam int DCNT_W = $clog2(NDIG);

  sida_state_t         state_r, state_nxt;
  logic [INT_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [BCD_W-1:0]    bcd_adj;
  logic [BCNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DCNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [6:0]          out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic [INT_BITS-1:0] raw;
  logic [3:0]          top_digit;
  logic                slot_free;
  logic                in_take;

  assign in_stall      = (state_r != ST_IDLE);
  assign in_take       = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;
  assign slot_free     = !out_valid_r || !out_stall;
  assign raw           = in_value;
  assign top_digit     = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = bcd_adjust(bcd_r[i*4 +: 4]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          neg_nxt     = raw[INT_BITS-1];
          mag_nxt     = raw[INT_BITS-1] ? (~raw + {{(INT_BITS-1){1'b0}}, 1'b1}) : raw;
          bcd_nxt     = '0;
          bit_cnt_nxt = BCNT_W'(INT_BITS - 1);
          dig_cnt_nxt = DCNT_W'(NDIG - 1);
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[INT_BITS-1]};
        mag_nxt     = {mag_r[INT_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == '0) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if ((top_digit == 4'd0) && (dig_cnt_r != '0)) begin
          bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + {3'b000, top_digit};
          out_last_nxt  = (dig_cnt_r == '0);
          bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt   = dig_cnt_r - 1'b1;
          if (dig_cnt_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_CONV))
    else $error("accepted request did not start conversion");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_r == ASCII_MINUS)) |-> !out_last_r)
    else $error("minus sign flagged as last character");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_char_r == ASCII_MINUS) ||
                     ((out_char_r >= ASCII_ZERO) && (out_char_r <= ASCII_NINE))))
    else $error("illegal output character");

  a_conv_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CONV) && (state_nxt == ST_SKIP)) |-> (bit_cnt_r == '0))
    else $error("conversion ended early");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && slot_free && (dig_cnt_r == '0)) |=> (state_r == ST_IDLE))
    else $error("run did not end after last digit");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks signed_int_to_decimal_ascii. Random and edge-case 32-bit integers go
// in through the valid/stall request channel. A scoreboard builds the
// expected decimal characters of every accepted request, including the minus
// sign and the last flag. Each output character is then compared with the
// oldest pending one. Both channels idle at random, with one calm stretch.
// ----------------------------------------------------------------------------
class decimal_text_board;
  typedef struct {
    logic [6:0] char_code;
    logic       last;
  } text_char_t;

  text_char_t pending_chars[$];
  int         errors = 0;

  function void note_value(logic signed [31:0] value);
    logic [31:0] mag;
    logic [3:0]  digits[$];
    text_char_t  c;
    mag = value[31] ? (~value + 32'd1) : value;
    do begin
      digits.push_front(4'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    if (value[31]) begin
      c.char_code = sida_pkg::ASCII_MINUS;
      c.last      = 1'b0;
      pending_chars.push_back(c);
    end
    foreach (digits[i]) begin
      c.char_code = sida_pkg::ASCII_ZERO + 7'(digits[i]);
      c.last      = (i == digits.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function void check_char(logic [6:0] char_code, logic last);
    text_char_t c;
    if (pending_chars.size() == 0) begin
      $error("char_code: nothing pending, got %0d (last %0d)", char_code, last);
      errors++;
    end else begin
      c = pending_chars.pop_front();
      if (char_code !== c.char_code) begin
        $error("char_code: expected %0d, got %0d", c.char_code, char_code);
        errors++;
      end
      if (last !== c.last) begin
        $error("last: expected %0d, got %0d", c.last, last);
        errors++;
      end
    end
  endfunction

  function int pending();
    return pending_chars.size();
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 86;
  localparam int DRAIN_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [6:0]         out_char_code;
  logic               out_last;

  logic               calm = 1'b0;
  int                 cycles = 0;
  decimal_text_board  board = new();

  signed_int_to_decimal_ascii #(
    .INT_BITS(32)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      board.note_value(in_value);
    end
    if (rst_n && out_valid && !out_stall) begin
      board.check_char(out_char_code, out_last);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic send_value(input logic signed [31:0] value);
    int gap;
    gap = 0;
    while (!calm && gap < 8 && $urandom_range(99) < 36) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [31:0] random_value();
    logic [31:0] span;
    logic [31:0] v;
    int          n;
    span = 32'd1;
    n = $urandom_range(1, 9);
    repeat (n) span = span * 32'd10;
    case ($urandom_range(4))
      0, 1: v = $urandom;
      2:    v = $urandom_range(0, span - 1);
      3:    v = -$urandom_range(0, span - 1);
      default: begin
        v = span + $urandom_range(0, 2) - 32'd1;
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic signed [31:0] edge_values[$];
    edge_values = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
      -32'sd100, 32'sd2147483647, 32'h8000_0000, -32'sd2147483647,
      32'sd1000000000, 32'sd999999999, -32'sd999999999, 32'sd1234567890,
      -32'sd5, 32'sd7, 32'h5555_5555, 32'haaaa_aaaa, 32'sd1000000,
      -32'sd1000000000, 32'sd2147483646, 32'sd0
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (edge_values[i]) begin
      send_value(edge_values[i]);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 40 && i < 70);
      send_value(random_value());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
